### rtl/dual_note_priority_tracker_macros.svh
// ----------------------------------------------------------------------------
// Dual note priority tracker assertion macros
// Shared helpers for the concurrent checks in the tracker's modules.
// ----------------------------------------------------------------------------
`ifndef DUAL_NOTE_PRIORITY_TRACKER_MACROS_SVH
`define DUAL_NOTE_PRIORITY_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DNPT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define DNPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dnpt_pkg.sv
// ----------------------------------------------------------------------------
// Dual note priority tracker package
// Types, message codes and sizes shared by the tracker's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dnpt_pkg;

	// Default sizes
	localparam int NOTE_COUNT_DEF      = 128;
	localparam int PRESS_COUNT_MAX_DEF = 15;

	// Field widths
	localparam int FUNC_W     = 4;
	localparam int NOTE_W     = 7;
	localparam int BEND_W     = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 1;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Channel message status nibbles
	localparam logic [FUNC_W-1:0] FN_NOTE_OFF = 4'h8;
	localparam logic [FUNC_W-1:0] FN_NOTE_ON  = 4'h9;
	localparam logic [FUNC_W-1:0] FN_CONTROL  = 4'hb;
	localparam logic [FUNC_W-1:0] FN_BEND     = 4'he;

	localparam logic [NOTE_W-1:0] CC_SUSTAIN       = 7'h40;
	localparam logic [NOTE_W-1:0] PEDAL_THRESHOLD  = 7'd63;
	localparam logic [NOTE_W-1:0] RELEASE_VELOCITY = 7'd64;
	localparam logic [BEND_W-1:0] BEND_CENTRE      = 14'd8192;
	localparam logic [NOTE_W:0]   NO_NOTE          = 8'd128;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_HOLD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_RETRIG_ALL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_RETRIG_ALL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_SKIP_FIRST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_SKIP_FIRST = 3'd4;

	// Classified operation carried from front to back
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PRESS,
		OP_RELEASE,
		OP_PEDAL,
		OP_BEND
	} op_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [NOTE_W-1:0] data_one;
		logic [NOTE_W-1:0] data_two;
	} msg_t;

	typedef struct packed {
		logic [NOTE_W-1:0] lower_note;
		logic [NOTE_W-1:0] lower_velocity;
		logic [NOTE_W-1:0] upper_note;
		logic [NOTE_W-1:0] upper_velocity;
		logic              note_gate;
		logic              gate_out;
		logic              lower_retrigger;
		logic              upper_retrigger;
		logic              lower_skip_glide;
		logic              upper_skip_glide;
		logic [BEND_W-1:0] pitch_bend;
	} result_t;

	typedef struct packed {
		logic sustain_hold_enable;
		logic lower_retrig_always;
		logic upper_retrig_always;
		logic lower_glide_first_skip;
		logic upper_glide_first_skip;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [NOTE_W-1:0] note;
		logic [NOTE_W-1:0] value;
	} cmd_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

`default_nettype wire

### rtl/dnpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dnpt_ram #(
	parameter int WIDTH = dnpt_pkg::NOTE_W,
	parameter int DEPTH = dnpt_pkg::NOTE_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/dnpt_front.sv
// ----------------------------------------------------------------------------
// Dual note priority tracker front end
// Classifies incoming channel messages and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_note_priority_tracker_macros.svh"

module dnpt_front #(
	parameter int NOTE_COUNT = dnpt_pkg::NOTE_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire dnpt_pkg::msg_t   msg,
	output dnpt_pkg::head_t       head,
	input  wire logic             head_pop
);

	localparam logic [dnpt_pkg::NOTE_W:0] NOTE_LIMIT = (dnpt_pkg::NOTE_W + 1)'(NOTE_COUNT);
	localparam int CNT_W = dnpt_pkg::QUEUE_PTR_W + 1;

	dnpt_pkg::cmd_t                     cmd_c;
	logic                               note_ok;
	logic                               accept;
	logic                               do_pop;
	dnpt_pkg::cmd_t                     q_mem_q [dnpt_pkg::QUEUE_DEPTH];
	logic [dnpt_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [dnpt_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]                   cnt_q;

	// Classify the request
	always_comb begin
		note_ok    = {1'b0, msg.data_one} < NOTE_LIMIT;
		cmd_c.op    = dnpt_pkg::OP_NONE;
		cmd_c.note  = msg.data_one;
		cmd_c.value = msg.data_two;
		case (msg.func)
			dnpt_pkg::FN_NOTE_OFF: begin
				if (note_ok) begin
					cmd_c.op = dnpt_pkg::OP_RELEASE;
				end
			end
			dnpt_pkg::FN_NOTE_ON: begin
				if (note_ok) begin
					if (msg.data_two != '0) begin
						cmd_c.op = dnpt_pkg::OP_PRESS;
					end else begin
						// zero velocity note on is a release
						cmd_c.op    = dnpt_pkg::OP_RELEASE;
						cmd_c.value = dnpt_pkg::RELEASE_VELOCITY;
					end
				end
			end
			dnpt_pkg::FN_CONTROL: begin
				if (msg.data_one == dnpt_pkg::CC_SUSTAIN) begin
					cmd_c.op = dnpt_pkg::OP_PEDAL;
				end
			end
			dnpt_pkg::FN_BEND: begin
				cmd_c.op = dnpt_pkg::OP_BEND;
			end
			default: begin
			end
		endcase
	end

	assign full   = cnt_q == CNT_W'(dnpt_pkg::QUEUE_DEPTH);
	assign accept = push && !full;
	assign do_pop = head_pop && head.valid;

	// Queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= cmd_c;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !accept) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head.valid = cnt_q != '0;
	assign head.cmd   = q_mem_q[rd_ptr_q];

	`DNPT_ASSERT_NEXT(a_push_grows_queue, clk, arst_n, accept && !do_pop, cnt_q == CNT_W'($past(cnt_q) + 1'b1), "queue count did not grow on push")
	`DNPT_ASSERT_NEXT(a_pop_shrinks_queue, clk, arst_n, do_pop && !accept, cnt_q == CNT_W'($past(cnt_q) - 1'b1), "queue count did not shrink on pop")
	`DNPT_ASSERT_IMPL(a_count_in_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(dnpt_pkg::QUEUE_DEPTH), "queue count past its depth")

endmodule

`default_nettype wire

### rtl/dnpt_back.sv
// ----------------------------------------------------------------------------
// Dual note priority tracker back end
// Updates press counts and velocities, scans for the lowest and highest
// held note, and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_note_priority_tracker_macros.svh"

module dnpt_back #(
	parameter int NOTE_COUNT      = dnpt_pkg::NOTE_COUNT_DEF,
	parameter int PRESS_COUNT_MAX = dnpt_pkg::PRESS_COUNT_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dnpt_pkg::cfg_t    cfg,
	input  wire dnpt_pkg::head_t   head,
	output logic                   head_pop,
	output dnpt_pkg::result_t      result,
	output logic                   empty,
	input  wire logic              pop
);

	localparam int NW     = $clog2(NOTE_COUNT);
	localparam int CW     = $clog2(PRESS_COUNT_MAX + 1);
	localparam int GROUPS = (NOTE_COUNT + 7) / 8;
	localparam int GW     = $clog2(GROUPS);
	localparam int IW     = GW + 3;
	localparam int PADW   = GROUPS * 8;
	localparam int NTW    = dnpt_pkg::NOTE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SCAN,
		ST_VEL,
		ST_DONE
	} state_t;

	state_t               state_q;
	dnpt_pkg::cmd_t       cmd_q;
	logic [NOTE_COUNT-1:0] held_q;
	logic                 pedal_down_q;
	logic                 pedal_gate_q;
	logic [1:0]           skip_q;
	logic [dnpt_pkg::BEND_W-1:0] bend_q;
	logic [NTW:0]         last_lower_q;
	logic [NTW:0]         last_upper_q;
	logic [NTW-1:0]       held_lower_q;
	logic [NTW-1:0]       held_upper_q;
	logic [NTW-1:0]       lower_vel_q;
	logic [NTW-1:0]       upper_vel_q;
	logic [NW-1:0]        lo_q;
	logic [NW-1:0]        hi_q;
	logic                 found_q;
	dnpt_pkg::result_t    out_q;
	logic                 out_valid_q;

	logic                 any_held;
	logic [NW-1:0]        head_idx;
	logic [NW-1:0]        cur_idx;
	logic                 pedal_next;
	logic                 cnt_we;
	logic [CW-1:0]        cnt_rdata;
	logic [CW-1:0]        cnt_cur;
	logic [CW-1:0]        cnt_next;
	logic                 vel_we;
	logic [NTW-1:0]       vel_lo_rdata;
	logic [NTW-1:0]       vel_hi_rdata;

	logic [PADW-1:0]      held_pad;
	logic [GROUPS-1:0]    grp_any_c;
	logic [2:0]           grp_lo_c [GROUPS];
	logic [2:0]           grp_hi_c [GROUPS];
	logic [GROUPS-1:0]    grp_any_s1;
	logic [2:0]           grp_lo_s1 [GROUPS];
	logic [2:0]           grp_hi_s1 [GROUPS];
	logic [IW-1:0]        lo_full_c;
	logic [IW-1:0]        hi_full_c;
	logic [NW-1:0]        lo_idx_c;
	logic [NW-1:0]        hi_idx_c;
	logic                 found_c;

	logic [NTW-1:0]       lo_note;
	logic [NTW-1:0]       hi_note;
	logic [NTW:0]         lo_ext;
	logic [NTW:0]         hi_ext;
	logic                 rl_c;
	logic                 ru_c;
	logic                 out_free;
	dnpt_pkg::result_t    res_c;

	assign any_held   = |held_q;
	assign head_idx   = head.cmd.note[NW-1:0];
	assign cur_idx    = cmd_q.note[NW-1:0];
	assign head_pop   = (state_q == ST_IDLE) && head.valid;
	assign pedal_next = cfg.sustain_hold_enable && (head.cmd.value > dnpt_pkg::PEDAL_THRESHOLD);

	// Press count update; the held bit marks an entry as valid
	assign cnt_cur = held_q[cur_idx] ? cnt_rdata : '0;
	always_comb begin
		cnt_next = cnt_cur;
		case (cmd_q.op)
			dnpt_pkg::OP_PRESS: begin
				if (cnt_cur < CW'(PRESS_COUNT_MAX)) begin
					cnt_next = cnt_cur + 1'b1;
				end
			end
			dnpt_pkg::OP_RELEASE: begin
				if (cnt_cur != '0) begin
					cnt_next = cnt_cur - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cnt_we = (state_q == ST_COUNT) &&
		((cmd_q.op == dnpt_pkg::OP_PRESS) || (cmd_q.op == dnpt_pkg::OP_RELEASE));

	dnpt_ram #(
		.WIDTH (CW),
		.DEPTH (NOTE_COUNT)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cur_idx),
		.wdata (cnt_next),
		.raddr (head_idx),
		.rdata (cnt_rdata)
	);

	// Velocity store, one copy per voice read port
	assign vel_we = head_pop &&
		((head.cmd.op == dnpt_pkg::OP_PRESS) || (head.cmd.op == dnpt_pkg::OP_RELEASE));

	dnpt_ram #(
		.WIDTH (NTW),
		.DEPTH (NOTE_COUNT)
	) u_vel_lo_ram (
		.clk   (clk),
		.we    (vel_we),
		.waddr (head_idx),
		.wdata (head.cmd.value),
		.raddr (lo_idx_c),
		.rdata (vel_lo_rdata)
	);

	dnpt_ram #(
		.WIDTH (NTW),
		.DEPTH (NOTE_COUNT)
	) u_vel_hi_ram (
		.clk   (clk),
		.we    (vel_we),
		.waddr (head_idx),
		.wdata (head.cmd.value),
		.raddr (hi_idx_c),
		.rdata (vel_hi_rdata)
	);

	// First scan level: lowest and highest held bit within each group of eight
	always_comb begin
		held_pad = PADW'(held_q);
		for (int g = 0; g < GROUPS; g++) begin
			grp_any_c[g] = |held_pad[g*8 +: 8];
			grp_lo_c[g]  = '0;
			grp_hi_c[g]  = '0;
			for (int b = 7; b >= 0; b--) begin
				if (held_pad[g*8 + b]) begin
					grp_lo_c[g] = 3'(b);
				end
			end
			for (int b = 0; b < 8; b++) begin
				if (held_pad[g*8 + b]) begin
					grp_hi_c[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s1 <= grp_any_c;
		grp_lo_s1  <= grp_lo_c;
		grp_hi_s1  <= grp_hi_c;
	end

	// Second scan level: pick the lowest and highest occupied group
	always_comb begin
		lo_full_c = '0;
		hi_full_c = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				lo_full_c = {GW'(g), grp_lo_s1[g]};
			end
		end
		for (int g = 0; g < GROUPS; g++) begin
			if (grp_any_s1[g]) begin
				hi_full_c = {GW'(g), grp_hi_s1[g]};
			end
		end
		found_c  = |grp_any_s1;
		lo_idx_c = lo_full_c[NW-1:0];
		hi_idx_c = hi_full_c[NW-1:0];
	end

	// Retrigger decision and result assembly
	always_comb begin
		lo_note  = NTW'(lo_q);
		hi_note  = NTW'(hi_q);
		lo_ext   = {1'b0, lo_note};
		hi_ext   = {1'b0, hi_note};
		rl_c     = found_q && (lo_ext != last_lower_q) &&
			(cfg.lower_retrig_always || (lo_ext < last_lower_q));
		ru_c     = found_q && (hi_ext != last_upper_q) &&
			(cfg.upper_retrig_always || (last_upper_q == dnpt_pkg::NO_NOTE) ||
			(hi_ext > last_upper_q));
		out_free = !out_valid_q || pop;

		res_c.lower_note       = found_q ? lo_note : held_lower_q;
		res_c.lower_velocity   = found_q ? vel_lo_rdata : lower_vel_q;
		res_c.upper_note       = found_q ? hi_note : held_upper_q;
		res_c.upper_velocity   = found_q ? vel_hi_rdata : upper_vel_q;
		res_c.note_gate        = found_q;
		res_c.gate_out         = found_q || pedal_gate_q;
		res_c.lower_retrigger  = rl_c;
		res_c.upper_retrigger  = ru_c;
		res_c.lower_skip_glide = skip_q[0];
		res_c.upper_skip_glide = skip_q[1];
		res_c.pitch_bend       = bend_q;
	end

	// Sequencer, tracker state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= '0;
			held_q       <= '0;
			pedal_down_q <= 1'b0;
			pedal_gate_q <= 1'b0;
			skip_q       <= '0;
			bend_q       <= dnpt_pkg::BEND_CENTRE;
			last_lower_q <= dnpt_pkg::NO_NOTE;
			last_upper_q <= dnpt_pkg::NO_NOTE;
			held_lower_q <= '0;
			held_upper_q <= '0;
			lower_vel_q  <= '0;
			upper_vel_q  <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			found_q      <= 1'b0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// Result valid: set when loaded, cleared when taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						cmd_q   <= head.cmd;
						state_q <= ST_COUNT;
						case (head.cmd.op)
							dnpt_pkg::OP_PRESS: begin
								skip_q <= {!any_held && cfg.upper_glide_first_skip,
									!any_held && cfg.lower_glide_first_skip};
								pedal_gate_q <= pedal_down_q;
							end
							dnpt_pkg::OP_PEDAL: begin
								pedal_down_q <= pedal_next;
								pedal_gate_q <= any_held && pedal_next;
							end
							dnpt_pkg::OP_BEND: begin
								bend_q <= {head.cmd.value, head.cmd.note};
							end
							default: begin
							end
						endcase
					end
				end
				ST_COUNT: begin
					if (cmd_q.op == dnpt_pkg::OP_PRESS) begin
						held_q[cur_idx] <= 1'b1;
					end else if (cmd_q.op == dnpt_pkg::OP_RELEASE) begin
						held_q[cur_idx] <= cnt_next != '0;
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					state_q <= ST_VEL;
				end
				ST_VEL: begin
					lo_q    <= lo_idx_c;
					hi_q    <= hi_idx_c;
					found_q <= found_c;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_q <= res_c;
						if (found_q) begin
							held_lower_q <= lo_note;
							held_upper_q <= hi_note;
							lower_vel_q  <= vel_lo_rdata;
							upper_vel_q  <= vel_hi_rdata;
							last_lower_q <= lo_ext;
							last_upper_q <= hi_ext;
						end else begin
							last_lower_q <= dnpt_pkg::NO_NOTE;
							last_upper_q <= dnpt_pkg::NO_NOTE;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

	`DNPT_ASSERT_IMPL(a_result_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_DONE, "result loaded outside the final step")
	`DNPT_ASSERT_IMPL(a_lower_not_above_upper, clk, arst_n, out_valid_q && out_q.note_gate, out_q.lower_note <= out_q.upper_note, "lower note above upper note")
	`DNPT_ASSERT_IMPL(a_found_notes_held, clk, arst_n, (state_q == ST_DONE) && found_q, held_q[lo_q] && held_q[hi_q], "scan picked a note that is not held")
	`DNPT_ASSERT_NEXT(a_press_sets_held, clk, arst_n, (state_q == ST_COUNT) && (cmd_q.op == dnpt_pkg::OP_PRESS), held_q[$past(cur_idx)], "pressed note not marked held")

endmodule

`default_nettype wire

### rtl/dual_note_priority_tracker.sv
// ----------------------------------------------------------------------------
// Dual note priority tracker
// The back-end sequencer handles one request at a time: press count
// read-modify-write, two-level held-note scan, velocity read, then the
// result register, which waits while the previous result is not popped.
// A 2-entry command queue lets requests be taken while the back end works.
// Reset: asynchronous; registers clear, held bits mask RAMs; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_note_priority_tracker #(
	parameter int NOTE_COUNT      = dnpt_pkg::NOTE_COUNT_DEF,
	parameter int PRESS_COUNT_MAX = dnpt_pkg::PRESS_COUNT_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire dnpt_pkg::msg_t                    msg,
	output logic                                   empty,
	input  wire logic                              pop,
	output dnpt_pkg::result_t                      result,
	input  wire logic                              cfg_write,
	input  wire logic [dnpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dnpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dnpt_pkg::cfg_t  cfg_q;
	dnpt_pkg::head_t head;
	logic            head_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sustain_hold_enable    <= 1'b1;
			cfg_q.lower_retrig_always    <= 1'b0;
			cfg_q.upper_retrig_always    <= 1'b0;
			cfg_q.lower_glide_first_skip <= 1'b0;
			cfg_q.upper_glide_first_skip <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				dnpt_pkg::CFG_SUSTAIN_HOLD:     cfg_q.sustain_hold_enable    <= cfg_data[0];
				dnpt_pkg::CFG_LOWER_RETRIG_ALL: cfg_q.lower_retrig_always    <= cfg_data[0];
				dnpt_pkg::CFG_UPPER_RETRIG_ALL: cfg_q.upper_retrig_always    <= cfg_data[0];
				dnpt_pkg::CFG_LOWER_SKIP_FIRST: cfg_q.lower_glide_first_skip <= cfg_data[0];
				dnpt_pkg::CFG_UPPER_SKIP_FIRST: cfg_q.upper_glide_first_skip <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Classify and queue requests
	dnpt_front #(
		.NOTE_COUNT (NOTE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.msg      (msg),
		.head     (head),
		.head_pop (head_pop)
	);

	// Execute requests and hold the result
	dnpt_back #(
		.NOTE_COUNT      (NOTE_COUNT),
		.PRESS_COUNT_MAX (PRESS_COUNT_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.head_pop (head_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

`default_nettype wire
